// ===== rtl/qte_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg
// Widths, constants and the arctangent table of the quaternion to Euler unit.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int QW       = 16;            // quaternion component width
    localparam int AW       = 16;            // angle width
    localparam int QFRAC    = QW - 2;        // component fraction bits
    localparam int PW       = 2 * QW - QFRAC; // floored product width
    localparam int TW       = PW + 3;        // angle term width
    localparam int SQN      = QW - 1;        // square root steps
    localparam int VW       = 2 * SQN;       // square root radicand width
    localparam int REMW     = SQN + 4;       // square root remainder width
    localparam int CST      = 16;            // CORDIC stages
    localparam int CW       = TW + 3;        // CORDIC x and y width
    localparam int AFRAC    = 30;            // CORDIC angle fraction bits
    localparam int ZW       = AFRAC + 4;     // CORDIC angle width
    localparam int RSH      = AFRAC - (AW - 3);
    localparam int NVEC     = 3;

    localparam int VEC_PITCH = 0;
    localparam int VEC_YAW   = 1;
    localparam int VEC_ROLL  = 2;

    localparam logic signed [ZW-1:0] HALF_PI = ZW'(64'sd1686629713);
    localparam logic signed [TW-1:0] ONE     = TW'(1) <<< QFRAC;
    localparam logic signed [AW-1:0] ANG_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ANG_MIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [AW-1:0] PITCH_LIM = AW'(12868);

    typedef struct packed {
        logic signed [TW-1:0] sr;
        logic signed [TW-1:0] cr;
        logic signed [TW-1:0] sp;
        logic signed [TW-1:0] sy;
        logic signed [TW-1:0] cy;
        logic                 clamp;
    } t_terms;

    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return $signed({{(ZW-32){1'b0}}, v});
    endfunction

endpackage
`default_nettype wire

// ===== rtl/quaternion_to_euler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit
// Converts a Q1.14 quaternion into Z-Y-X Euler angles in Q2.13 radians.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while the output is not stalled, through
// one product stage, one term stage, fifteen square root stages for the pitch
// cosine, one quadrant stage, sixteen CORDIC stages run in step for the
// three angles, and one output register. A stall on the output holds the
// whole pipeline.
module quaternion_to_euler_unit
    import qte_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output      logic                 o_stall,
    input  wire logic signed [QW-1:0] i_quat_w,
    input  wire logic signed [QW-1:0] i_quat_x,
    input  wire logic signed [QW-1:0] i_quat_y,
    input  wire logic signed [QW-1:0] i_quat_z,
    output      logic                 o_valid,
    input  wire logic                 i_stall,
    output      logic signed [AW-1:0] o_pitch_angle,
    output      logic signed [AW-1:0] o_yaw_angle,
    output      logic signed [AW-1:0] o_roll_angle,
    output      logic                 o_pitch_clamped
);

    logic en;

    // Product stage.
    logic                 r_v1;
    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;

    // Term stage and square root stages.
    logic [SQN:0]           r_sv;
    t_terms                 r_tm   [0:SQN];
    logic [VW-1:0]          r_rad  [0:SQN];
    logic [REMW-1:0]        r_rem  [0:SQN];
    logic [SQN-1:0]         r_root [0:SQN];

    // CORDIC stages.
    logic [CST:0]           r_cv;
    logic signed [CW-1:0]   r_cx   [0:CST][NVEC];
    logic signed [CW-1:0]   r_cy   [0:CST][NVEC];
    logic signed [ZW-1:0]   r_cz   [0:CST][NVEC];
    logic [NVEC-1:0]        r_zero [0:CST];
    logic                   r_clmp [0:CST];
    logic                   r_spos [0:CST];

    logic                   r_ov;
    logic signed [AW-1:0]   r_ang  [NVEC];
    logic                   r_oclamp;

    function automatic logic signed [PW-1:0] mulq(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        return p[2*QW-1:QFRAC];
    endfunction

    function automatic logic signed [TW-1:0] ext(input logic signed [PW-1:0] a);
        return TW'(a);
    endfunction

    function automatic logic signed [AW-1:0] angle_out(input logic signed [ZW-1:0] a);
        logic signed [ZW:0]     t;
        logic signed [ZW-RSH:0] r;
        t = (ZW+1)'(a) + ((ZW+1)'(1) <<< (RSH - 1));
        r = t[ZW:RSH];
        if (r > (ZW-RSH+1)'(ANG_MAX)) begin
            return ANG_MAX;
        end else if (r < (ZW-RSH+1)'(ANG_MIN)) begin
            return ANG_MIN;
        end
        return r[AW-1:0];
    endfunction

    assign en      = !(r_ov && i_stall);
    assign o_stall = r_ov && i_stall;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= mulq(i_quat_w, i_quat_x);
            r_yz <= mulq(i_quat_y, i_quat_z);
            r_xx <= mulq(i_quat_x, i_quat_x);
            r_yy <= mulq(i_quat_y, i_quat_y);
            r_wy <= mulq(i_quat_w, i_quat_y);
            r_zx <= mulq(i_quat_z, i_quat_x);
            r_wz <= mulq(i_quat_w, i_quat_z);
            r_xy <= mulq(i_quat_x, i_quat_y);
            r_zz <= mulq(i_quat_z, i_quat_z);
        end
    end

    t_terms                 n_tm0;
    logic [VW-1:0]          n_rad0;
    logic signed [2*QW-1:0] sp_sq;

    always_comb begin
        n_tm0.sr    = (ext(r_wx) + ext(r_yz)) <<< 1;
        n_tm0.cr    = ONE - ((ext(r_xx) + ext(r_yy)) <<< 1);
        n_tm0.sp    = (ext(r_wy) - ext(r_zx)) <<< 1;
        n_tm0.sy    = (ext(r_wz) + ext(r_xy)) <<< 1;
        n_tm0.cy    = ONE - ((ext(r_yy) + ext(r_zz)) <<< 1);
        n_tm0.clamp = (n_tm0.sp >= ONE) || (n_tm0.sp <= -ONE);
        sp_sq       = $signed(n_tm0.sp[QW-1:0]) * $signed(n_tm0.sp[QW-1:0]);
        n_rad0      = (VW'(1) << (2 * QFRAC)) - sp_sq[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tm[0]   <= n_tm0;
            r_rad[0]  <= n_rad0;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    // One root bit per stage, restoring digit-by-digit square root.
    logic [REMW-1:0] n_rem  [SQN];
    logic [SQN-1:0]  n_root [SQN];

    always_comb begin
        logic [REMW-1:0] remx;
        logic [REMW-1:0] trial;
        for (int s = 0; s < SQN; s++) begin
            remx  = {r_rem[s][REMW-3:0], r_rad[s][VW-1 -: 2]};
            trial = {{(REMW-SQN-2){1'b0}}, r_root[s], 2'b01};
            if (remx >= trial) begin
                n_rem[s]  = remx - trial;
                n_root[s] = {r_root[s][SQN-2:0], 1'b1};
            end else begin
                n_rem[s]  = remx;
                n_root[s] = {r_root[s][SQN-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < SQN; s++) begin
                r_tm[s+1]   <= r_tm[s];
                r_rad[s+1]  <= r_rad[s] << 2;
                r_rem[s+1]  <= n_rem[s];
                r_root[s+1] <= n_root[s];
            end
        end
    end

    // Quadrant correction into the right half plane.
    logic signed [CW-1:0] vx [NVEC];
    logic signed [CW-1:0] vy [NVEC];
    logic signed [CW-1:0] n_x0 [NVEC];
    logic signed [CW-1:0] n_y0 [NVEC];
    logic signed [ZW-1:0] n_z0 [NVEC];
    logic [NVEC-1:0]      n_zero0;

    always_comb begin
        vy[VEC_PITCH] = CW'(r_tm[SQN].sp);
        vx[VEC_PITCH] = CW'({1'b0, r_root[SQN]});
        vy[VEC_YAW]   = CW'(r_tm[SQN].sy);
        vx[VEC_YAW]   = CW'(r_tm[SQN].cy);
        vy[VEC_ROLL]  = CW'(r_tm[SQN].sr);
        vx[VEC_ROLL]  = CW'(r_tm[SQN].cr);
        for (int k = 0; k < NVEC; k++) begin
            n_zero0[k] = (vx[k] == '0) && (vy[k] == '0);
            n_x0[k]    = vx[k];
            n_y0[k]    = vy[k];
            n_z0[k]    = '0;
            if (vx[k] < 0) begin
                if (vy[k] >= 0) begin
                    n_x0[k] = vy[k];
                    n_y0[k] = -vx[k];
                    n_z0[k] = HALF_PI;
                end else begin
                    n_x0[k] = -vy[k];
                    n_y0[k] = vx[k];
                    n_z0[k] = -HALF_PI;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NVEC; k++) begin
                r_cx[0][k] <= n_x0[k];
                r_cy[0][k] <= n_y0[k];
                r_cz[0][k] <= n_z0[k];
            end
            r_zero[0] <= n_zero0;
            r_clmp[0] <= r_tm[SQN].clamp;
            r_spos[0] <= r_tm[SQN].sp > 0;
        end
    end

    // Vectoring CORDIC, one micro-rotation per stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < CST; i++) begin
                for (int k = 0; k < NVEC; k++) begin
                    if (r_cy[i][k] >= 0) begin
                        r_cx[i+1][k] <= r_cx[i][k] + (r_cy[i][k] >>> i);
                        r_cy[i+1][k] <= r_cy[i][k] - (r_cx[i][k] >>> i);
                        r_cz[i+1][k] <= r_cz[i][k] + atan_entry(i);
                    end else begin
                        r_cx[i+1][k] <= r_cx[i][k] - (r_cy[i][k] >>> i);
                        r_cy[i+1][k] <= r_cy[i][k] + (r_cx[i][k] >>> i);
                        r_cz[i+1][k] <= r_cz[i][k] - atan_entry(i);
                    end
                end
                r_zero[i+1] <= r_zero[i];
                r_clmp[i+1] <= r_clmp[i];
                r_spos[i+1] <= r_spos[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NVEC; k++) begin
                if (k == VEC_PITCH && r_clmp[CST]) begin
                    r_ang[k] <= angle_out(r_spos[CST] ? HALF_PI : -HALF_PI);
                end else begin
                    r_ang[k] <= r_zero[CST][k] ? '0 : angle_out(r_cz[CST][k]);
                end
            end
            r_oclamp <= r_clmp[CST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_sv <= '0;
            r_cv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_sv <= {r_sv[SQN-1:0], r_v1};
            r_cv <= {r_cv[CST-1:0], r_sv[SQN]};
            r_ov <= r_cv[CST];
        end
    end

    assign o_valid         = r_ov;
    assign o_pitch_angle   = r_ang[VEC_PITCH];
    assign o_yaw_angle     = r_ang[VEC_YAW];
    assign o_roll_angle    = r_ang[VEC_ROLL];
    assign o_pitch_clamped = r_oclamp;

    a_clamp_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pitch_clamped) |->
        (o_pitch_angle == PITCH_LIM || o_pitch_angle == -PITCH_LIM))
        else $error("clamped pitch is not a quarter turn");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> ($stable(r_cv) && $stable(r_sv) && $stable(r_v1)))
        else $error("pipeline moved during an output stall");

endmodule
`default_nettype wire

// ===== tb/tb_quaternion_to_euler_unit.sv =====
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_unit
// Self-checking bench for the quaternion to Euler angle unit.
// ----------------------------------------------------------------------------
// Directed quaternions cover the component extremes, the pitch clamp on both
// sides, the zero vector and negative abscissas. Random quaternions follow,
// mostly in [-1, 1] per component, partly raw, with random gaps on both sides.
// Each accepted result is checked against an angle predictor in the bench.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_unit;
    import qte_pkg::*;

    typedef struct {
        logic signed [AW-1:0] pitch;
        logic signed [AW-1:0] yaw;
        logic signed [AW-1:0] roll;
        logic                 clamped;
    } t_angles;

    localparam longint HALF_PI_Q = 64'sd1686629713;
    localparam int     IDLE_LIMIT = 5000;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint tab(int i);
        longint t [16] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                           64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                           64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                           64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
        return t[i];
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = HALF_PI_Q;
            end else begin
                x = -y; y = t; z = -HALF_PI_Q;
            end
        end
        for (int i = 0; i < 16; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += tab(i);
            end else begin
                x -= dx; y += dy; z -= tab(i);
            end
        end
        return z;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [AW-1:0] to_angle(longint a);
        longint r;
        r = floor_shift(a + (64'sd1 <<< (RSH - 1)), RSH);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[AW-1:0];
    endfunction

    function automatic longint qmul(longint a, longint b);
        return floor_shift(a * b, QFRAC);
    endfunction

    function automatic t_angles euler_of(logic signed [QW-1:0] qw, logic signed [QW-1:0] qx,
                                         logic signed [QW-1:0] qy, logic signed [QW-1:0] qz);
        t_angles r;
        longint w, x, y, z, one, sr, cr, sp, sy, cy, p;
        w = qw; x = qx; y = qy; z = qz;
        one = 64'sd1 <<< QFRAC;
        sr = 2 * (qmul(w, x) + qmul(y, z));
        cr = one - 2 * (qmul(x, x) + qmul(y, y));
        sp = 2 * (qmul(w, y) - qmul(z, x));
        sy = 2 * (qmul(w, z) + qmul(x, y));
        cy = one - 2 * (qmul(y, y) + qmul(z, z));
        if (sp >= one || sp <= -one) begin
            p = (sp > 0) ? HALF_PI_Q : -HALF_PI_Q;
            r.clamped = 1'b1;
        end else begin
            p = vector_angle(sp, int_sqrt(one * one - sp * sp));
            r.clamped = 1'b0;
        end
        r.pitch = to_angle(p);
        r.yaw = to_angle(vector_angle(sy, cy));
        r.roll = to_angle(vector_angle(sr, cr));
        return r;
    endfunction

    class angle_scoreboard;
        t_angles pending[$];
        int      mismatches;
        int      checked;

        function void note_quat(logic signed [QW-1:0] w, logic signed [QW-1:0] x,
                                logic signed [QW-1:0] y, logic signed [QW-1:0] z);
            pending.push_back(euler_of(w, x, y, z));
        endfunction

        function void check_angles(t_angles got);
            t_angles want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item");
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.pitch !== want.pitch || got.yaw !== want.yaw ||
                got.roll !== want.roll || got.clamped !== want.clamped) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp p=%0d y=%0d r=%0d c=%0b got p=%0d y=%0d r=%0d c=%0b",
                             want.pitch, want.yaw, want.roll, want.clamped,
                             got.pitch, got.yaw, got.roll, got.clamped);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 i_stall = 1'b0;
    logic signed [QW-1:0] i_quat_w = '0, i_quat_x = '0, i_quat_y = '0, i_quat_z = '0;
    logic                 o_stall, o_valid, o_pitch_clamped;
    logic signed [AW-1:0] o_pitch_angle, o_yaw_angle, o_roll_angle;

    angle_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  driving_done = 0;

    quaternion_to_euler_unit u_top (.*);

    initial forever #5 i_clk = ~i_clk;

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_quat(logic signed [QW-1:0] w, logic signed [QW-1:0] x,
                             logic signed [QW-1:0] y, logic signed [QW-1:0] z);
        int g;
        g = gap_len();
        if (g != 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_quat_w <= w; i_quat_x <= x; i_quat_y <= y; i_quat_z <= z;
        do @(posedge i_clk); while (o_stall);
        sb.note_quat(w, x, y, z);
        @(negedge i_clk);
    endtask

    function automatic logic signed [QW-1:0] near_unit();
        return $signed(16'($urandom_range(0, 32768) - 16384));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_angles('{o_pitch_angle, o_yaw_angle, o_roll_angle, o_pitch_clamped});
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            if (driving_done) begin
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                g = gap_len();
                if (g != 0) begin
                    i_stall <= 1'b1;
                    repeat (g) @(negedge i_clk);
                end
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        logic signed [QW-1:0] a, b, c, d;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_quat(16'sd16384, 0, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(11585, 11585, 11585, 11585);
        send_quat(0, 16'sd16384, 0, 0);
        send_quat(0, 0, 0, 16'sd16384);
        send_quat(0, 0, 16'sd16384, 0);
        send_quat(11585, 11585, 0, 0);
        send_quat(0, 11585, 0, 11585);
        send_quat(-11585, 0, 11585, 0);
        send_quat(8192, 8192, 8192, -8192);
        send_quat(1, -1, 1, -1);
        send_quat(16'sd32767, 0, 0, 0);
        send_quat(0, -16'sd32768, 0, 0);
        for (int n = 0; n < 1200; n++) begin
            if ($urandom_range(0, 3) != 0) begin
                a = near_unit(); b = near_unit(); c = near_unit(); d = near_unit();
            end else begin
                a = QW'($urandom); b = QW'($urandom); c = QW'($urandom); d = QW'($urandom);
            end
            send_quat(a, b, c, d);
        end
        i_valid <= 1'b0;
        driving_done = 1;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("checked %0d angle result items from %0d directed and random quaternions",
                 sb.checked, 1218);
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("mismatches: %0d", sb.mismatches);
            $display("simulation failed");
        end
        $finish;
    end
endmodule
